/* rtl/crc7fc_pkg.sv */
`default_nettype none

package crc7fc_pkg;

    localparam logic [7:0] POLY_RESET = 8'd221;
    localparam logic [7:0] PAD_RESET  = 8'd32;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_POLY = 2'd1;
    localparam logic [1:0] REG_PAD  = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    localparam logic [1:0] POS_FULL = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_CHECK   = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      out_kind;
        logic       frame_error;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic       mode;
        logic [7:0] polynomial;
        logic [7:0] pad_value;
    } t_cfg;

    // one accepted byte that gives results, plus what the emitter needs
    typedef struct packed {
        logic       verdict;
        logic       complete;
        logic [1:0] npad;
        logic [7:0] data_byte;
        logic [7:0] pad_byte;
        logic [7:0] recv_byte;
    } t_job;

    // bits 23 down to 15 of the long division
    function automatic logic [23:0] crc_upper(input logic [23:0] f, input logic [7:0] poly);
        logic [23:0] v;
        v = f;
        for (int b = 23; b >= 15; b--) begin
            if (v[b]) begin
                v = v ^ ({16'd0, poly} << (b - 7));
            end
        end
        return v;
    endfunction

    // bits 14 down to 7, leaves the check byte
    function automatic logic [7:0] crc_lower(input logic [23:0] f, input logic [7:0] poly);
        logic [23:0] v;
        v = f;
        for (int b = 14; b >= 7; b--) begin
            if (v[b]) begin
                v = v ^ ({16'd0, poly} << (b - 7));
            end
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/crc7fc_regs.sv */
`default_nettype none

module crc7fc_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [crc7fc_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [crc7fc_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [crc7fc_pkg::DATA_W-1:0]   o_prdata,
    output logic                                 o_pready,
    output crc7fc_pkg::t_cfg                     o_cfg,
    output logic                                 o_mode_wr
);
    import crc7fc_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign o_pready  = 1'b1;
    assign w_wr      = i_psel && i_penable && i_pwrite && o_pready;
    assign w_idx     = i_paddr[3:2];
    assign o_mode_wr = w_wr && (w_idx == REG_MODE);
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_ENCODE;
            r_cfg.polynomial <= POLY_RESET;
            r_cfg.pad_value  <= PAD_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE: r_cfg.mode       <= i_pwdata[0];
                REG_POLY: r_cfg.polynomial <= i_pwdata[7:0];
                REG_PAD:  r_cfg.pad_value  <= i_pwdata[7:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE: o_prdata = {{(DATA_W-1){1'b0}}, r_cfg.mode};
            REG_POLY: o_prdata = {{(DATA_W-8){1'b0}}, r_cfg.polynomial};
            REG_PAD:  o_prdata = {{(DATA_W-8){1'b0}}, r_cfg.pad_value};
            default:  o_prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/crc7fc_frame.sv */
`default_nettype none

module crc7fc_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire crc7fc_pkg::t_cfg     i_cfg,
    input  wire logic                 i_mode_wr,
    input  wire logic                 i_valid,
    input  wire crc7fc_pkg::t_in_beat i_in,
    output logic                      o_stall,
    input  wire logic                 i_down_ready,
    output logic                      o_valid,
    output crc7fc_pkg::t_job          o_job,
    output logic [23:0]               o_frame
);
    import crc7fc_pkg::*;

    logic [1:0]  r_pos;
    logic [23:0] r_held;
    logic        r_valid;
    t_job        r_job;
    logic [23:0] r_frame;

    logic [1:0]  n_pos;
    logic [23:0] n_held;
    logic        w_ready;
    logic        w_acc;
    logic        w_enter;
    t_job        w_job;
    logic [23:0] w_frame;
    logic [1:0]  w_p;
    logic [23:0] w_placed;

    assign w_ready = !r_valid || i_down_ready;
    assign o_stall = !w_ready;
    assign w_acc   = i_valid && w_ready;

    always_comb begin
        w_p      = (r_pos == POS_FULL) ? 2'd0 : r_pos;
        w_placed = r_held | ({16'd0, i_in.data_byte} << {w_p, 3'b000});
        n_pos    = r_pos;
        n_held   = r_held;
        w_enter  = 1'b0;
        w_frame  = w_placed;

        w_job.verdict   = 1'b0;
        w_job.complete  = 1'b0;
        w_job.npad      = 2'd0;
        w_job.data_byte = i_in.data_byte;
        w_job.pad_byte  = i_cfg.pad_value;
        w_job.recv_byte = i_in.data_byte;

        if (i_cfg.mode == MODE_ENCODE) begin
            w_enter        = 1'b1;
            w_job.complete = (w_p == 2'd2) || i_in.end_of_message;
            if (w_job.complete) begin
                w_job.npad = 2'd2 - w_p;
                if (w_p == 2'd0) begin
                    w_frame[15:8] = i_cfg.pad_value;
                end
                if (w_p != 2'd2) begin
                    w_frame[23:16] = i_cfg.pad_value;
                end
                n_pos  = 2'd0;
                n_held = '0;
            end else begin
                n_pos  = w_p + 2'd1;
                n_held = w_placed;
            end
        end else if (r_pos == POS_FULL) begin
            // fourth byte of the frame is the received check byte
            w_enter       = 1'b1;
            w_job.verdict = 1'b1;
            w_frame       = r_held;
            n_pos         = 2'd0;
            n_held        = '0;
        end else if (i_in.end_of_message) begin
            n_pos  = 2'd0;
            n_held = '0;
        end else begin
            n_pos  = r_pos + 2'd1;
            n_held = w_placed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_mode_wr) begin
                r_pos  <= '0;
                r_held <= '0;
            end else if (w_acc) begin
                r_pos  <= n_pos;
                r_held <= n_held;
            end
            if (w_ready) begin
                r_valid <= w_acc && w_enter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready) begin
            r_job   <= w_job;
            r_frame <= w_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign o_frame = r_frame;

    a_encode_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.mode == MODE_ENCODE) |-> (r_pos != POS_FULL))
        else $error("encode frame position ran past three bytes");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_valid)
        else $error("input stalled with empty first stage");

endmodule

`default_nettype wire

/* rtl/crc7fc_reduce.sv */
`default_nettype none

module crc7fc_reduce (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_poly,
    input  wire logic                 i_valid,
    input  wire crc7fc_pkg::t_job     i_job,
    input  wire logic [23:0]          i_frame,
    output logic                      o_ready,
    input  wire logic                 i_down_ready,
    output logic                      o_valid,
    output crc7fc_pkg::t_job          o_job,
    output logic [23:0]               o_frame
);
    import crc7fc_pkg::*;

    logic        r_valid;
    t_job        r_job;
    logic [23:0] r_frame;
    logic        w_ready;

    assign w_ready = !r_valid || i_down_ready;
    assign o_ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    // upper half of the division
    always_ff @(posedge i_clk) begin
        if (w_ready) begin
            r_job   <= i_job;
            r_frame <= crc_upper(i_frame, i_poly);
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign o_frame = r_frame;

endmodule

`default_nettype wire

/* rtl/crc7fc_emit.sv */
`default_nettype none

module crc7fc_emit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_poly,
    input  wire logic                 i_valid,
    input  wire crc7fc_pkg::t_job     i_job,
    input  wire logic [23:0]          i_frame,
    output logic                      o_ready,
    output logic                      o_valid,
    output crc7fc_pkg::t_out_beat     o_out,
    input  wire logic                 i_stall
);
    import crc7fc_pkg::*;

    logic       r_valid;
    logic [1:0] r_beat;
    t_job       r_job;
    logic [7:0] r_chk;

    logic       w_fire;
    logic       w_last;
    logic       w_free;
    logic [1:0] w_last_idx;

    always_comb begin
        if (r_job.verdict || !r_job.complete) begin
            w_last_idx = 2'd0;
        end else begin
            w_last_idx = r_job.npad + 2'd1;
        end
    end

    assign w_last  = (r_beat == w_last_idx);
    assign w_fire  = r_valid && !i_stall;
    assign w_free  = !r_valid || (w_fire && w_last);
    assign o_ready = w_free;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (w_free) begin
            r_valid <= i_valid;
            r_beat  <= '0;
        end else if (w_fire) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    // lower half of the division
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_job <= i_job;
            r_chk <= crc_lower(i_frame, i_poly);
        end
    end

    always_comb begin
        o_out.frame_error = 1'b0;
        o_out.last        = w_last;
        if (r_job.verdict) begin
            o_out.out_byte    = 8'd0;
            o_out.out_kind    = KIND_VERDICT;
            o_out.frame_error = (r_chk != r_job.recv_byte);
        end else if (r_beat == 2'd0) begin
            o_out.out_byte = r_job.data_byte;
            o_out.out_kind = KIND_DATA;
        end else if (w_last) begin
            o_out.out_byte = r_chk;
            o_out.out_kind = KIND_CHECK;
        end else begin
            o_out.out_byte = r_job.pad_byte;
            o_out.out_kind = KIND_DATA;
        end
    end

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_beat <= w_last_idx))
        else $error("beat counter past end of item");

    a_verdict_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_job.verdict) |-> (r_beat == 2'd0))
        else $error("verdict spans more than one beat");

endmodule

`default_nettype wire

/* rtl/crc7_frame_check_codec.sv */
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_in  (t_in_beat: data_byte, end_of_message)
// result    out        o_valid / i_stall   o_out (t_out_beat: out_byte, out_kind,
//                                                 frame_error, last)
// config    in         apb write / read    i_paddr, i_pwdata, o_prdata
//
// one byte can enter every cycle while o_stall is low; results pass the frame, reduce and emit registers
// one result beat per cycle while i_stall is low: a full encode frame gives four beats for
// three bytes and a one-byte message gives four, so the result port sets the rate in encode mode
// division is split across two register stages, nine then eight bit steps
// synchronous active-low reset clears frame state and config to defaults
// o_stall rises only while the first stage holds a byte that cannot move on
`default_nettype none

module crc7_frame_check_codec (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire crc7fc_pkg::t_in_beat            i_in,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output crc7fc_pkg::t_out_beat                o_out,
    input  wire logic                            i_stall,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [crc7fc_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [crc7fc_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [crc7fc_pkg::DATA_W-1:0]   o_prdata,
    output logic                                 o_pready
);
    import crc7fc_pkg::*;

    t_cfg        w_cfg;
    logic        w_mode_wr;

    logic        w_s1_valid;
    t_job        w_s1_job;
    logic [23:0] w_s1_frame;
    logic        w_s2_ready;

    logic        w_s2_valid;
    t_job        w_s2_job;
    logic [23:0] w_s2_frame;
    logic        w_em_ready;

    crc7fc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg),
        .o_mode_wr (w_mode_wr)
    );

    crc7fc_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_mode_wr    (w_mode_wr),
        .i_valid      (i_valid),
        .i_in         (i_in),
        .o_stall      (o_stall),
        .i_down_ready (w_s2_ready),
        .o_valid      (w_s1_valid),
        .o_job        (w_s1_job),
        .o_frame      (w_s1_frame)
    );

    crc7fc_reduce u_reduce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poly       (w_cfg.polynomial),
        .i_valid      (w_s1_valid),
        .i_job        (w_s1_job),
        .i_frame      (w_s1_frame),
        .o_ready      (w_s2_ready),
        .i_down_ready (w_em_ready),
        .o_valid      (w_s2_valid),
        .o_job        (w_s2_job),
        .o_frame      (w_s2_frame)
    );

    crc7fc_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poly  (w_cfg.polynomial),
        .i_valid (w_s2_valid),
        .i_job   (w_s2_job),
        .i_frame (w_s2_frame),
        .o_ready (w_em_ready),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire
